// ----- sv/rau_pkg.sv -----
// Package for the rational arithmetic unit: item structs, opcodes and the
// signed-magnitude helper. No dependencies.
package rau_pkg;

   // Opcodes of the input item.
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_NEG = 3'd4;
   localparam logic [2:0] OP_RCP = 3'd5;
   localparam logic [2:0] OP_NRM = 3'd6;
   localparam logic [2:0] OP_CMP = 3'd7;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } rau_req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               greater;
      logic               equal;
      logic               less;
      logic               zero_den;
      logic               overflow;
   } rau_rsp_type;

   // Sign and magnitude of a wide intermediate value.
   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } rau_sm_type;

   // Signed-magnitude addition; on a tie of magnitudes the first sign wins.
   function automatic rau_sm_type rau_add_sm(input rau_sm_type p, input rau_sm_type q);
      rau_sm_type r;
      if (p.neg == q.neg) begin
         r.neg = p.neg;
         r.mag = p.mag + q.mag;
      end else if (p.mag >= q.mag) begin
         r.neg = p.neg;
         r.mag = p.mag - q.mag;
      end else begin
         r.neg = q.neg;
         r.mag = q.mag - p.mag;
      end
      return r;
   endfunction

endpackage

// ----- sv/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: bit-serial multiplier, binary GCD and restoring
// dividers around one sequencer. Depends on rau_pkg.
//
// Usage: an item on the req_ channel carries an opcode and two fractions.
// It is accepted at a clock edge with req_valid high and req_stall low.
// req_stall stays high while an item is being worked on; one item is in
// the block at a time. The result leaves on the rsp_ channel from an output
// register, so the next item may be accepted while a result waits there.
// The sequencer works in steps: three shift-and-add passes form the cross
// products, then the binary GCD runs one shift or subtract per cycle, then
// two restoring dividers divide numerator and denominator by the GCD.
// Negate, reciprocal and normalize skip the products, and compare or zero
// results skip the rest.
// A zero input denominator goes from idle straight to the output state.
// Reset empties the output register and returns the sequencer to idle.
// While rsp_stall is high the finished result holds; a further finished
// result waits inside the block until the output register is free.
// WIDTH sets the range used for the overflow flag.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rau_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rau_rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_COMB = 6'b000100,
      ST_GCD  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } rau_state_type;

   localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

   rau_state_type state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic        an_s_ff, ad_s_ff, bn_s_ff, bd_s_ff;
   logic        an_s_in, ad_s_in, bn_s_in, bd_s_in;
   logic [31:0] an_m_ff, ad_m_ff, bn_m_ff, bd_m_ff;
   logic [31:0] an_m_in, ad_m_in, bn_m_in, bd_m_in;
   logic [63:0] mc_ff, mc_in, acc_ff, acc_in;
   logic [31:0] mp_ff, mp_in;
   logic [4:0]  bit_ff, bit_in;
   logic [1:0]  pass_ff, pass_in;
   logic [63:0] p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [63:0] x_ff, x_in, y_ff, y_in, qn_ff, qn_in, qd_ff, qd_in;
   logic [63:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   rau_rsp_type res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rau_rsp_type rsp_data_ff, rsp_data_in;

   // Signed-magnitude form of the incoming fields.
   logic        q_an_s, q_ad_s, q_bn_s, q_bd_s;
   logic [31:0] q_an_m, q_ad_m, q_bn_m, q_bd_m;
   logic        accept, uses_b, bad_in;

   assign q_an_s = req_data.a_num[31];
   assign q_ad_s = req_data.a_den[31];
   assign q_bn_s = req_data.b_num[31];
   assign q_bd_s = req_data.b_den[31];
   assign q_an_m = q_an_s ? (32'd0 - req_data.a_num) : req_data.a_num;
   assign q_ad_m = q_ad_s ? (32'd0 - req_data.a_den) : req_data.a_den;
   assign q_bn_m = q_bn_s ? (32'd0 - req_data.b_num) : req_data.b_num;
   assign q_bd_m = q_bd_s ? (32'd0 - req_data.b_den) : req_data.b_den;
   assign accept = req_valid && !req_stall;
   assign uses_b = (req_data.opcode <= OP_DIV) || (req_data.opcode == OP_CMP);
   assign bad_in = (q_ad_m == 32'd0) || (uses_b && (q_bd_m == 32'd0));

   // Operands of each multiplier pass.
   logic [31:0] pa_m, pb_m;
   logic        mp_bit;
   logic [63:0] acc_sum;
   logic [1:0]  next_pass;

   assign next_pass = pass_ff + 2'd1;
   always_comb begin
      unique case (next_pass)
         2'd1: begin
            pa_m = ad_m_ff;
            pb_m = bn_m_ff;
         end
         default: begin
            pa_m = ad_m_ff;
            pb_m = bd_m_ff;
         end
      endcase
   end
   assign mp_bit  = mp_ff[0];
   assign acc_sum = mp_bit ? (acc_ff + mc_ff) : acc_ff;

   // Numerator, denominator and compare difference from the products.
   rau_sm_type n_sel, d_sel, t1, t2, diff;
   logic       cmp_pos;

   always_comb begin
      t1.neg = an_s_ff ^ bd_s_ff;
      t1.mag = p1_ff;
      t2.neg = ad_s_ff ^ bn_s_ff;
      t2.mag = p2_ff;
      diff   = rau_add_sm(t1, '{neg: !t2.neg, mag: t2.mag});
      n_sel  = t1;
      d_sel.neg = ad_s_ff ^ bd_s_ff;
      d_sel.mag = p3_ff;
      unique case (op_ff)
         OP_ADD: n_sel = rau_add_sm(t1, t2);
         OP_SUB: n_sel = rau_add_sm(t1, '{neg: !t2.neg, mag: t2.mag});
         OP_MUL: n_sel = '{neg: an_s_ff ^ bn_s_ff, mag: p1_ff};
         OP_DIV: d_sel = t2;
         OP_NEG: begin
            n_sel = '{neg: !an_s_ff, mag: {32'd0, an_m_ff}};
            d_sel = '{neg: ad_s_ff, mag: {32'd0, ad_m_ff}};
         end
         OP_RCP: begin
            n_sel = '{neg: ad_s_ff, mag: {32'd0, ad_m_ff}};
            d_sel = '{neg: an_s_ff, mag: {32'd0, an_m_ff}};
         end
         OP_NRM: begin
            n_sel = '{neg: an_s_ff, mag: {32'd0, an_m_ff}};
            d_sel = '{neg: ad_s_ff, mag: {32'd0, ad_m_ff}};
         end
         default: n_sel = t1;
      endcase
   end
   assign cmp_pos = (!diff.neg) != (ad_s_ff != bd_s_ff);

   // One restoring division step for each quotient.
   logic [64:0] tn, td;
   logic        bn_q, bd_q;
   logic [63:0] qn_step, qd_step, rn_step, rd_step;

   assign tn      = {rn_ff, qn_ff[63]};
   assign td      = {rd_ff, qd_ff[63]};
   assign bn_q    = tn >= {1'b0, x_ff};
   assign bd_q    = td >= {1'b0, x_ff};
   assign rn_step = bn_q ? 64'(tn - {1'b0, x_ff}) : tn[63:0];
   assign rd_step = bd_q ? 64'(td - {1'b0, x_ff}) : td[63:0];
   assign qn_step = {qn_ff[62:0], bn_q};
   assign qd_step = {qd_ff[62:0], bd_q};

   // Final range check and result of a finished division.
   logic        fin_ovf;
   rau_rsp_type fin_res;

   always_comb begin
      fin_ovf = (neg_ff ? (qn_step > LIM + 64'd1) : (qn_step > LIM)) || (qd_step > LIM);
      fin_res = '0;
      if (fin_ovf) begin
         fin_res.overflow = 1'b1;
      end else begin
         fin_res.res_num = neg_ff ? (32'd0 - qn_step[31:0]) : qn_step[31:0];
         fin_res.res_den = qd_step[30:0];
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      an_s_in = an_s_ff; ad_s_in = ad_s_ff; bn_s_in = bn_s_ff; bd_s_in = bd_s_ff;
      an_m_in = an_m_ff; ad_m_in = ad_m_ff; bn_m_in = bn_m_ff; bd_m_in = bd_m_ff;
      mc_in = mc_ff; mp_in = mp_ff; acc_in = acc_ff; bit_in = bit_ff; pass_in = pass_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      x_in = x_ff; y_in = y_ff; qn_in = qn_ff; qd_in = qd_ff;
      rn_in = rn_ff; rd_in = rd_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_data.opcode;
               an_s_in = q_an_s; ad_s_in = q_ad_s; bn_s_in = q_bn_s; bd_s_in = q_bd_s;
               an_m_in = q_an_m; ad_m_in = q_ad_m; bn_m_in = q_bn_m; bd_m_in = q_bd_m;
               mc_in   = {32'd0, q_an_m};
               mp_in   = (req_data.opcode == OP_MUL) ? q_bn_m : q_bd_m;
               acc_in  = '0;
               bit_in  = '0;
               pass_in = '0;
               res_in  = '0;
               if (bad_in) begin
                  res_in.zero_den = 1'b1;
                  state_in = ST_OUT;
               end else if (uses_b) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_COMB;
               end
            end
         end
         ST_MUL: begin
            acc_in = acc_sum;
            mc_in  = {mc_ff[62:0], 1'b0};
            mp_in  = {1'b0, mp_ff[31:1]};
            bit_in = bit_ff + 5'd1;
            if (bit_ff == 5'd31) begin
               unique case (pass_ff)
                  2'd0:    p1_in = acc_sum;
                  2'd1:    p2_in = acc_sum;
                  default: p3_in = acc_sum;
               endcase
               acc_in  = '0;
               mc_in   = {32'd0, pa_m};
               mp_in   = pb_m;
               pass_in = next_pass;
               if (pass_ff == 2'd2) begin
                  state_in = ST_COMB;
               end
            end
         end
         ST_COMB: begin
            res_in = '0;
            if (op_ff == OP_CMP) begin
               if (diff.mag == 64'd0) begin
                  res_in.equal = 1'b1;
               end else if (cmp_pos) begin
                  res_in.greater = 1'b1;
               end else begin
                  res_in.less = 1'b1;
               end
               state_in = ST_OUT;
            end else if (d_sel.mag == 64'd0) begin
               res_in.zero_den = 1'b1;
               state_in = ST_OUT;
            end else if (n_sel.mag == 64'd0) begin
               res_in.res_den = 31'd1;
               state_in = ST_OUT;
            end else begin
               x_in   = n_sel.mag;
               y_in   = d_sel.mag;
               qn_in  = n_sel.mag;
               qd_in  = d_sel.mag;
               neg_in = n_sel.neg != d_sel.neg;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // Binary GCD; common factors of two leave both quotients as well.
            priority if ((x_ff == 64'd0) || (y_ff == 64'd0)) begin
               x_in   = x_ff | y_ff;
               rn_in  = '0;
               rd_in  = '0;
               cnt_in = '0;
               state_in = ST_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in  = {1'b0, x_ff[63:1]};
               y_in  = {1'b0, y_ff[63:1]};
               qn_in = {1'b0, qn_ff[63:1]};
               qd_in = {1'b0, qd_ff[63:1]};
            end else if (!x_ff[0]) begin
               x_in = {1'b0, x_ff[63:1]};
            end else if (!y_ff[0]) begin
               y_in = {1'b0, y_ff[63:1]};
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         ST_DIV: begin
            rn_in  = rn_step;
            rd_in  = rd_step;
            qn_in  = qn_step;
            qd_in  = qd_step;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               res_in   = fin_res;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Registers; only control state is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      an_s_ff <= an_s_in; ad_s_ff <= ad_s_in; bn_s_ff <= bn_s_in; bd_s_ff <= bd_s_in;
      an_m_ff <= an_m_in; ad_m_ff <= ad_m_in; bn_m_ff <= bn_m_in; bd_m_ff <= bd_m_in;
      mc_ff <= mc_in; mp_ff <= mp_in; acc_ff <= acc_in; bit_ff <= bit_in; pass_ff <= pass_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      x_ff <= x_in; y_ff <= y_in; qn_ff <= qn_in; qd_ff <= qd_in;
      rn_ff <= rn_in; rd_ff <= rd_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted item keeps the input side stalled in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input taken while an item is in progress");

   // At most one compare flag is set in a result.
   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_data.greater, rsp_data.equal, rsp_data.less}))
      else $error("more than one compare flag set");

   // A zero-denominator result carries no fraction.
   a_zero_den_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_den) |->
      (rsp_data.res_num == 32'd0 && rsp_data.res_den == 31'd0))
      else $error("fraction present with zero denominator flag");

   // An arithmetic result without error has a non-zero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.zero_den && !rsp_data.overflow && !rsp_data.greater &&
       !rsp_data.equal && !rsp_data.less) |-> (rsp_data.res_den != 31'd0))
      else $error("reduced denominator is zero");

endmodule

// ----- verif/tb_rational_arithmetic_unit.sv -----
// Self-checking testbench for the rational arithmetic unit.
// Depends on rau_pkg and rational_arithmetic_unit; predicts each result item.
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   localparam int WIDTH = 32;
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   rau_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rau_rsp_type rsp_data;

   rau_req_type pending_items[$];
   rau_rsp_type expected_results[$];
   int          mismatch_count = 0;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   int          hold_count;
   int          quiet_cycles;

   rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sign and magnitude of a 32-bit field.
   function automatic rau_sm_type to_sm(input logic [31:0] x);
      rau_sm_type r;
      r.neg = x[31];
      r.mag = x[31] ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
      return r;
   endfunction

   function automatic rau_sm_type sm_times(input rau_sm_type p, input rau_sm_type q);
      rau_sm_type r;
      r.neg = p.neg != q.neg;
      r.mag = p.mag * q.mag;
      return r;
   endfunction

   function automatic rau_sm_type sm_plus(input rau_sm_type p, input rau_sm_type q);
      rau_sm_type r;
      if (p.neg == q.neg) begin
         r.neg = p.neg;
         r.mag = p.mag + q.mag;
      end else if (p.mag >= q.mag) begin
         r.neg = p.neg;
         r.mag = p.mag - q.mag;
      end else begin
         r.neg = q.neg;
         r.mag = q.mag - p.mag;
      end
      return r;
   endfunction

   // Exact reduced fraction, comparison and flags for one item.
   function automatic rau_rsp_type reduce_fraction(input rau_req_type it);
      rau_rsp_type r;
      rau_sm_type  an, ad, bn, bd, n, d, t;
      logic [63:0] x, y, g, nm, dm, lim;
      logic        neg, uses_b;
      an = to_sm(it.a_num);
      ad = to_sm(it.a_den);
      bn = to_sm(it.b_num);
      bd = to_sm(it.b_den);
      r = '0;
      uses_b = (it.opcode <= OP_DIV) || (it.opcode == OP_CMP);
      lim = (64'd1 << (WIDTH - 1)) - 64'd1;
      if (ad.mag == 0 || (uses_b && bd.mag == 0)) begin
         r.zero_den = 1'b1;
         return r;
      end
      // Compare by cross-multiplication; the sign of the denominators fixes direction.
      if (it.opcode == OP_CMP) begin
         t = sm_times(ad, bn);
         t.neg = !t.neg;
         n = sm_plus(sm_times(an, bd), t);
         if (n.mag == 0) r.equal = 1'b1;
         else if ((!n.neg) != (ad.neg != bd.neg)) r.greater = 1'b1;
         else r.less = 1'b1;
         return r;
      end
      unique case (it.opcode)
         OP_ADD, OP_SUB: begin
            t = sm_times(ad, bn);
            if (it.opcode == OP_SUB) t.neg = !t.neg;
            n = sm_plus(sm_times(an, bd), t);
            d = sm_times(ad, bd);
         end
         OP_MUL: begin
            n = sm_times(an, bn);
            d = sm_times(ad, bd);
         end
         OP_DIV: begin
            n = sm_times(an, bd);
            d = sm_times(ad, bn);
         end
         OP_NEG: begin
            n = an;
            n.neg = !n.neg;
            d = ad;
         end
         OP_RCP: begin
            n = ad;
            d = an;
         end
         default: begin
            n = an;
            d = ad;
         end
      endcase
      if (d.mag == 0) begin
         r.zero_den = 1'b1;
         return r;
      end
      if (n.mag == 0) begin
         neg = 1'b0;
         nm = 0;
         dm = 1;
      end else begin
         x = n.mag;
         y = d.mag;
         while (y != 0) begin
            g = x % y;
            x = y;
            y = g;
         end
         neg = n.neg != d.neg;
         nm = n.mag / x;
         dm = d.mag / x;
      end
      if ((neg ? nm > lim + 1 : nm > lim) || dm > lim) begin
         r.overflow = 1'b1;
         return r;
      end
      r.res_num = 32'(neg ? (64'd0 - nm) : nm);
      r.res_den = dm[30:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatch_count++;
   endtask

   // Operand values biased towards edge cases.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(0, 20)) - 10);
         4, 5: return 32'($urandom_range(1, 200));
         6: return -32'($urandom_range(1, 200));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(input logic [2:0] op, input logic [31:0] an,
                             input logic [31:0] ad, input logic [31:0] bn,
                             input logic [31:0] bd);
      rau_req_type it;
      it.opcode = op;
      it.a_num = an;
      it.a_den = ad;
      it.b_num = bn;
      it.b_den = bd;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      int n;
      while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clock);
      for (n = 0; n < 500; n++) @(posedge clock);
   endtask

   // Driver: offers the head of the pending queue, with random idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(reduce_fraction(req_data));
            void'(pending_items.pop_front());
         end
         if (req_valid && req_stall) begin
            // Hold the stalled item unchanged.
         end else if (pending_items.size() != 0
                      && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_items[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall and result checking.
   always @(posedge clock) begin
      rau_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", {32'd0, rsp_data.res_num}, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.res_num !== want.res_num)
                  report_mismatch("res_num", 64'(rsp_data.res_num), 64'(want.res_num));
               if (rsp_data.res_den !== want.res_den)
                  report_mismatch("res_den", 64'(rsp_data.res_den), 64'(want.res_den));
               if (rsp_data.greater !== want.greater)
                  report_mismatch("greater", 64'(rsp_data.greater), 64'(want.greater));
               if (rsp_data.equal !== want.equal)
                  report_mismatch("equal", 64'(rsp_data.equal), 64'(want.equal));
               if (rsp_data.less !== want.less)
                  report_mismatch("less", 64'(rsp_data.less), 64'(want.less));
               if (rsp_data.zero_den !== want.zero_den)
                  report_mismatch("zero_den", 64'(rsp_data.zero_den), 64'(want.zero_den));
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", 64'(rsp_data.overflow), 64'(want.overflow));
            end
         end
         if (hold_off && hold_count < 3000) begin
            hold_count <= hold_count + 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles with no accepted item on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int ph, k;
      logic [2:0] op;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items: every opcode, extremes, zero denominators, overflow.
      queue_item(OP_ADD, 1, 2, 1, 3);
      queue_item(OP_SUB, 1, 2, 1, 2);
      queue_item(OP_MUL, -6, 4, 2, -3);
      queue_item(OP_DIV, 3, 5, 0, 7);
      queue_item(OP_DIV, 3, 5, 6, -10);
      queue_item(OP_NEG, 32'h8000_0000, 1, 0, 0);
      queue_item(OP_NEG, 5, -10, 1, 0);
      queue_item(OP_RCP, 0, 5, 0, 0);
      queue_item(OP_RCP, -4, 8, 9, 9);
      queue_item(OP_NRM, 0, -7, 0, 0);
      queue_item(OP_NRM, 32'h8000_0000, 32'h8000_0000, 1, 1);
      queue_item(OP_NRM, 1, 32'h8000_0000, 1, 1);
      queue_item(OP_CMP, 1, 2, 2, 4);
      queue_item(OP_CMP, 1, -2, 1, 3);
      queue_item(OP_CMP, 32'h7fff_ffff, 1, 32'h8000_0000, -1);
      queue_item(OP_ADD, 1, 0, 1, 1);
      queue_item(OP_MUL, 1, 1, 1, 0);
      queue_item(OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
      queue_item(OP_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
      queue_item(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0001);
      queue_item(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      drain();

      // Random phases: none, sender idle, receiver stalling, both.
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 78 : (ph == 3) ? 32 : 0;
         recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 32 : 0;
         for (k = 0; k < 400; k++) begin
            op = 3'($urandom_range(0, 7));
            queue_item(op, pick_value(), pick_value(), pick_value(), pick_value());
         end
         // Long receiver hold-off while the sender keeps offering items.
         if (ph == 0) hold_off = 1'b1;
         drain();
         hold_off = 1'b0;
      end

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
